>>> rtl/clc_pkg.sv
// shared types, register codes and constants for the cylinder local coordinate pipeline
`default_nettype none
package clc_pkg;

	localparam int CTR_W = 21;
	localparam int AX_W = 18;
	localparam int FR_W = 17;
	localparam int CFG_W = 63;
	localparam int IDX_W = 3;

	// pi in Q.30 and 1/K of the cordic gain in Q.20
	localparam longint PI_Q30 = 64'd3373259426;
	localparam logic [19:0] INVK_Q20 = 20'd636751;

	typedef enum logic [IDX_W-1:0] {
		REG_CENTER,
		REG_AXIS_U,
		REG_AXIS_V,
		REG_AXIS_W,
		REG_RADIUS,
		REG_LENGTH,
		REG_INSENS,
		REG_TRACK
	} cfg_reg_t;

	typedef struct packed {
		logic [3*CTR_W-1:0] center;
		logic [3*AX_W-1:0]  axis_u;
		logic [3*AX_W-1:0]  axis_v;
		logic [3*AX_W-1:0]  axis_w;
		logic [22:0]        radius;
		logic [23:0]        length;
		logic [FR_W-1:0]    frac_lo;
		logic [FR_W-1:0]    frac_hi;
		logic               track;
	} cfg_t;

	// arctangent of 2^-i in Q.30
	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd843314857;
			1: r = 32'd497837829;
			2: r = 32'd263043837;
			3: r = 32'd133525159;
			4: r = 32'd67021687;
			5: r = 32'd33543516;
			6: r = 32'd16775851;
			7: r = 32'd8388437;
			8: r = 32'd4194283;
			9: r = 32'd2097149;
			default: r = 32'(64'd1 << (30 - i));
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/clc_front.sv
// centre subtraction, axis projection, half-plane prep and range flags
`default_nettype none
module clc_front #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS = 16,
	parameter int C_W = 50
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_valid,
	input  wire logic signed [COORD_WIDTH-1:0]     pos_x,
	input  wire logic signed [COORD_WIDTH-1:0]     pos_y,
	input  wire logic signed [COORD_WIDTH-1:0]     pos_z,
	input  wire clc_pkg::cfg_t                     cfg,
	output logic                                   valid_s4,
	output logic signed [C_W-1:0]                  x_s4,
	output logic signed [C_W-1:0]                  y_s4,
	output logic signed [FRAC_BITS+3:0]            z_s4,
	output logic [COORD_WIDTH+4:0]                 side_s4
);
	import clc_pkg::*;

	localparam int UP_SH = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
	localparam int DN_SH = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
	localparam int D_W = ((COORD_WIDTH > CTR_W) ? COORD_WIDTH : CTR_W) + 1;
	localparam int M_W = D_W + AX_W;
	localparam int S_W = M_W + 2;
	localparam int X_W = (S_W > 48) ? S_W : 48;
	localparam int P_W = 48 + UP_SH;
	localparam int Z_W = FRAC_BITS + 4;
	localparam int O_W = COORD_WIDTH + 2;
	localparam int CMP_W = 60;
	localparam longint PI_F = (PI_Q30 + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
	localparam logic signed [X_W-1:0] LIM_P = X_W'(longint'(1) <<< 46);
	localparam logic signed [X_W-1:0] LIM_N = -LIM_P;
	localparam logic signed [P_W-1:0] RND_DN = P_W'((longint'(1) <<< DN_SH) >>> 1);
	localparam logic signed [P_W-1:0] RND_AX = P_W'(longint'(1) <<< (FRAC_BITS - 1));
	localparam logic signed [P_W-1:0] OMAX = P_W'((longint'(1) <<< (O_W - 1)) - 1);
	localparam logic signed [P_W-1:0] OMIN = -OMAX - P_W'(1);

	// stage 1: offset from centre
	logic signed [COORD_WIDTH-1:0] pos_a [3];
	logic signed [CTR_W-1:0]       ctr [3];
	logic signed [D_W-1:0]         d_s1 [3];
	logic                          v_s1;

	always_comb begin
		pos_a[0] = pos_x;
		pos_a[1] = pos_y;
		pos_a[2] = pos_z;
		for (int k = 0; k < 3; k++) begin
			ctr[k] = $signed(cfg.center[CTR_W*k +: CTR_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= D_W'(pos_a[k]) - D_W'(ctr[k]);
			end
		end
	end

	// stage 2: nine partial products
	logic signed [AX_W-1:0] ax [3][3];
	logic signed [M_W-1:0]  p_s2 [3][3];
	logic                   v_s2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ax[0][k] = $signed(cfg.axis_u[AX_W*k +: AX_W]);
			ax[1][k] = $signed(cfg.axis_v[AX_W*k +: AX_W]);
			ax[2][k] = $signed(cfg.axis_w[AX_W*k +: AX_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					p_s2[j][k] <= M_W'(d_s1[k]) * M_W'(ax[j][k]);
				end
			end
		end
	end

	// stage 3: sum, clamp and rescale to the working fraction
	logic signed [S_W-1:0] sum [3];
	logic signed [X_W-1:0] sx [3];
	logic signed [X_W-1:0] cl [3];
	logic signed [P_W-1:0] proj [3];
	logic signed [P_W-1:0] p_s3 [3];
	logic                  v_s3;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum[j] = S_W'(p_s2[j][0]) + S_W'(p_s2[j][1]) + S_W'(p_s2[j][2]);
			sx[j] = X_W'(sum[j]);
			if (sx[j] > LIM_P) begin
				cl[j] = LIM_P;
			end else if (sx[j] < LIM_N) begin
				cl[j] = LIM_N;
			end else begin
				cl[j] = sx[j];
			end
			proj[j] = ((P_W'(cl[j]) + RND_DN) >>> DN_SH) <<< UP_SH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				p_s3[j] <= proj[j];
			end
		end
	end

	// length limits are registered from the config registers and do not stop on a stall
	logic signed [CMP_W-1:0] lim_q, lneg_q, lpos_q;
	logic [40:0]             lf_lo, lf_hi;
	logic signed [CMP_W-1:0] lhalf;

	always_comb begin
		lf_lo = 41'(cfg.length) * 41'(cfg.frac_lo);
		lf_hi = 41'(cfg.length) * 41'(cfg.frac_hi);
		lhalf = CMP_W'($signed({1'b0, cfg.length, 15'b0}));
	end

	always_ff @(posedge clk) begin
		lim_q <= lhalf <<< UP_SH;
		lneg_q <= (lhalf - CMP_W'($signed({1'b0, lf_lo}))) <<< UP_SH;
		lpos_q <= (lhalf - CMP_W'($signed({1'b0, lf_hi}))) <<< UP_SH;
	end

	// stage 4: half-plane fold, axial output and flags
	logic signed [C_W-1:0]   x_n, y_n;
	logic signed [Z_W-1:0]   z_n;
	logic                    zero_n, inmat_n, insens_n;
	logic signed [CMP_W-1:0] vq;
	logic signed [P_W-1:0]   ax_r;
	logic signed [O_W-1:0]   axial_n;

	always_comb begin
		zero_n = (p_s3[0] == '0) && (p_s3[1] == '0);
		if (p_s3[0] < 0) begin
			x_n = -C_W'(p_s3[0]);
			y_n = -C_W'(p_s3[1]);
			z_n = (p_s3[1] >= 0) ? Z_W'(PI_F) : -Z_W'(PI_F);
		end else begin
			x_n = C_W'(p_s3[0]);
			y_n = C_W'(p_s3[1]);
			z_n = '0;
		end
		vq = CMP_W'(p_s3[2]) <<< DN_SH;
		inmat_n = (vq >= -lim_q) && (vq <= lim_q);
		insens_n = cfg.track && (vq >= -lneg_q) && (vq <= lpos_q);
		ax_r = (p_s3[2] + RND_AX) >>> FRAC_BITS;
		if (ax_r > OMAX) begin
			axial_n = O_W'(OMAX);
		end else if (ax_r < OMIN) begin
			axial_n = O_W'(OMIN);
		end else begin
			axial_n = O_W'(ax_r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4 <= x_n;
			y_s4 <= y_n;
			z_s4 <= z_n;
			side_s4 <= {zero_n, inmat_n, insens_n, axial_n};
		end
	end

endmodule
`default_nettype wire

>>> rtl/clc_cordic_stage.sv
// one vectoring cordic iteration with its pipeline register
`default_nettype none
module clc_cordic_stage #(
	parameter int C_W = 50,
	parameter int Z_W = 20,
	parameter int SIDE_W = 29,
	parameter int SHIFT = 0,
	parameter logic signed [Z_W-1:0] ATAN = '0
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     valid_i,
	input  wire logic signed [C_W-1:0]    x_i,
	input  wire logic signed [C_W-1:0]    y_i,
	input  wire logic signed [Z_W-1:0]    z_i,
	input  wire logic [SIDE_W-1:0]        side_i,
	output logic                          valid_q,
	output logic signed [C_W-1:0]         x_q,
	output logic signed [C_W-1:0]         y_q,
	output logic signed [Z_W-1:0]         z_q,
	output logic [SIDE_W-1:0]             side_q
);

	logic signed [C_W-1:0] xs, ys;

	// rotate toward the positive x axis
	always_comb begin
		xs = x_i >>> SHIFT;
		ys = y_i >>> SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			if (y_i < 0) begin
				x_q <= x_i - ys;
				y_q <= y_i + xs;
				z_q <= z_i - ATAN;
			end else begin
				x_q <= x_i + ys;
				y_q <= y_i - xs;
				z_q <= z_i + ATAN;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/clc_finish.sv
// angle wrap, gain correction, arc length and output saturation
`default_nettype none
module clc_finish #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS = 16,
	parameter int C_W = 50,
	parameter int Z_W = 20,
	parameter int SIDE_W = 29
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          valid_i,
	input  wire logic signed [C_W-1:0]         x_i,
	input  wire logic signed [Z_W-1:0]         z_i,
	input  wire logic [SIDE_W-1:0]             side_i,
	input  wire logic [22:0]                   radius,
	output logic                               out_valid,
	output logic signed [COORD_WIDTH+1:0]      arc_u,
	output logic signed [COORD_WIDTH+1:0]      axial_v,
	output logic signed [COORD_WIDTH+1:0]      radial_w,
	output logic                               in_material,
	output logic                               in_sensitive
);
	import clc_pkg::*;

	localparam int O_W = COORD_WIDTH + 2;
	localparam int XR_W = C_W - (FRAC_BITS - 8) - 1;
	localparam int HI_W = XR_W - 16 + 20;
	localparam int MP_W = XR_W + 21;
	localparam int MG_W = MP_W - 28;
	localparam int RD_W = ((MG_W > 24) ? MG_W : 24) + 2;
	localparam int AP_W = Z_W + 24;
	localparam longint PI_F = (PI_Q30 + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
	localparam logic signed [Z_W-1:0] PI_Z = Z_W'(PI_F);
	localparam logic signed [Z_W-1:0] TWO_PI_Z = Z_W'(2 * PI_F);
	localparam logic signed [C_W-1:0] XRND = C_W'(longint'(1) <<< (FRAC_BITS - 9));
	localparam logic [MP_W-1:0] MRND = MP_W'(64'd1 << 27);
	localparam logic signed [AP_W-1:0] ARND = AP_W'(longint'(1) <<< (FRAC_BITS - 1));
	localparam logic signed [RD_W-1:0] RMAX = RD_W'((longint'(1) <<< (O_W - 1)) - 1);
	localparam logic signed [RD_W-1:0] RMIN = -RMAX - RD_W'(1);
	localparam logic signed [AP_W-1:0] AMAX = AP_W'((longint'(1) <<< (O_W - 1)) - 1);
	localparam logic signed [AP_W-1:0] AMIN = -AMAX - AP_W'(1);

	// side word: zero flag, in-material, in-sensitive, axial result
	logic                  zero_i;
	logic signed [C_W-1:0] xsh;
	logic signed [Z_W-1:0] zw_n;

	always_comb begin
		zero_i = side_i[SIDE_W-1];
		xsh = (x_i + XRND) >>> (FRAC_BITS - 8);
		if (zero_i) begin
			zw_n = '0;
		end else if (z_i > PI_Z) begin
			zw_n = z_i - TWO_PI_Z;
		end else if (z_i <= -PI_Z) begin
			zw_n = z_i + TWO_PI_Z;
		end else begin
			zw_n = z_i;
		end
	end

	// stage f1: wrapped angle and rounded magnitude
	logic [XR_W-1:0]       xr_s1;
	logic signed [Z_W-1:0] zw_s1;
	logic [SIDE_W-2:0]     side_s1;
	logic                  v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xr_s1 <= zero_i ? '0 : xsh[XR_W-1:0];
			zw_s1 <= zw_n;
			side_s1 <= side_i[SIDE_W-2:0];
		end
	end

	// stage f2: gain products split in two halves, and radius times angle
	logic [35:0]            lo_s2;
	logic [HI_W-1:0]        hi_s2;
	logic signed [AP_W-1:0] ap_s2;
	logic [SIDE_W-2:0]      side_s2;
	logic                   v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2 <= 36'(xr_s1[15:0]) * 36'(INVK_Q20);
			hi_s2 <= HI_W'(xr_s1[XR_W-1:16]) * HI_W'(INVK_Q20);
			ap_s2 <= AP_W'($signed({1'b0, radius})) * AP_W'(zw_s1);
			side_s2 <= side_s1;
		end
	end

	// stage f3: round, subtract radius, saturate into the output register
	logic [MP_W-1:0]        mp;
	logic [MG_W-1:0]        mag;
	logic signed [RD_W-1:0] rd;
	logic signed [AP_W-1:0] ar;
	logic signed [O_W-1:0]  radial_n, arc_n;

	always_comb begin
		mp = (MP_W'(hi_s2) << 16) + MP_W'(lo_s2) + MRND;
		mag = mp[MP_W-1:28];
		rd = RD_W'($signed({1'b0, mag})) - RD_W'($signed({1'b0, radius}));
		if (rd > RMAX) begin
			radial_n = O_W'(RMAX);
		end else if (rd < RMIN) begin
			radial_n = O_W'(RMIN);
		end else begin
			radial_n = O_W'(rd);
		end
		ar = (ap_s2 + ARND) >>> FRAC_BITS;
		if (ar > AMAX) begin
			arc_n = O_W'(AMAX);
		end else if (ar < AMIN) begin
			arc_n = O_W'(AMIN);
		end else begin
			arc_n = O_W'(ar);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arc_u <= arc_n;
			radial_w <= radial_n;
			axial_v <= $signed(side_s2[O_W-1:0]);
			in_sensitive <= side_s2[O_W];
			in_material <= side_s2[O_W+1];
		end
	end

endmodule
`default_nettype wire

>>> rtl/cylinder_local_coords.sv
// path: front stages, the cordic stages, then the finish stages, from input transfer to result
// throughput: one point per cycle; the pipeline moves as one while the output is not stalled
// a held result freezes every stage, so in_stall follows out_stall while out_valid is high
// config writes reach the length limits through the config register and then the limit registers
// reset: arst_n clears every valid bit and loads centre 0, unit axes, all else 0
`default_nettype none
module cylinder_local_coords #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [COORD_WIDTH-1:0]       pos_x,
	input  wire logic signed [COORD_WIDTH-1:0]       pos_y,
	input  wire logic signed [COORD_WIDTH-1:0]       pos_z,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [COORD_WIDTH+1:0]            arc_u,
	output logic signed [COORD_WIDTH+1:0]            axial_v,
	output logic signed [COORD_WIDTH+1:0]            radial_w,
	output logic                                     in_material,
	output logic                                     in_sensitive,
	input  wire logic                                cfg_we,
	input  wire logic [clc_pkg::IDX_W-1:0]           cfg_index,
	input  wire logic [clc_pkg::CFG_W-1:0]           cfg_wdata
);
	import clc_pkg::*;

	localparam int UP_SH = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
	localparam int C_W = 48 + UP_SH + 2;
	localparam int Z_W = FRAC_BITS + 4;
	localparam int SIDE_W = COORD_WIDTH + 5;

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center <= '0;
			cfg_q.axis_u <= 54'd65536;
			cfg_q.axis_v <= 54'd65536 << AX_W;
			cfg_q.axis_w <= 54'd65536 << (2 * AX_W);
			cfg_q.radius <= '0;
			cfg_q.length <= '0;
			cfg_q.frac_lo <= '0;
			cfg_q.frac_hi <= '0;
			cfg_q.track <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER: cfg_q.center <= cfg_wdata;
				REG_AXIS_U: cfg_q.axis_u <= cfg_wdata[3*AX_W-1:0];
				REG_AXIS_V: cfg_q.axis_v <= cfg_wdata[3*AX_W-1:0];
				REG_AXIS_W: cfg_q.axis_w <= cfg_wdata[3*AX_W-1:0];
				REG_RADIUS: cfg_q.radius <= cfg_wdata[22:0];
				REG_LENGTH: cfg_q.length <= cfg_wdata[23:0];
				REG_INSENS: {cfg_q.frac_hi, cfg_q.frac_lo} <= cfg_wdata[2*FR_W-1:0];
				REG_TRACK:  cfg_q.track <= cfg_wdata[0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	// whole pipeline advances unless a result is held
	logic en;

	always_comb begin
		in_stall = out_valid && out_stall;
		en = !in_stall;
	end

	logic                  v_c [CORDIC_STAGES+1];
	logic signed [C_W-1:0] x_c [CORDIC_STAGES+1];
	logic signed [C_W-1:0] y_c [CORDIC_STAGES+1];
	logic signed [Z_W-1:0] z_c [CORDIC_STAGES+1];
	logic [SIDE_W-1:0]     s_c [CORDIC_STAGES+1];

	clc_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS(FRAC_BITS),
		.C_W(C_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.cfg(cfg_q),
		.valid_s4(v_c[0]),
		.x_s4(x_c[0]),
		.y_s4(y_c[0]),
		.z_s4(z_c[0]),
		.side_s4(s_c[0])
	);

	// cordic iterations, one register stage each
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		localparam logic [31:0] AQ = atan_q30(i);
		localparam logic signed [Z_W-1:0] AF =
			Z_W'((longint'(AQ) + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

		clc_cordic_stage #(
			.C_W(C_W),
			.Z_W(Z_W),
			.SIDE_W(SIDE_W),
			.SHIFT(i),
			.ATAN(AF)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_i(v_c[i]),
			.x_i(x_c[i]),
			.y_i(y_c[i]),
			.z_i(z_c[i]),
			.side_i(s_c[i]),
			.valid_q(v_c[i+1]),
			.x_q(x_c[i+1]),
			.y_q(y_c[i+1]),
			.z_q(z_c[i+1]),
			.side_q(s_c[i+1])
		);
	end

	clc_finish #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS(FRAC_BITS),
		.C_W(C_W),
		.Z_W(Z_W),
		.SIDE_W(SIDE_W)
	) u_finish (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_i(v_c[CORDIC_STAGES]),
		.x_i(x_c[CORDIC_STAGES]),
		.z_i(z_c[CORDIC_STAGES]),
		.side_i(s_c[CORDIC_STAGES]),
		.radius(cfg_q.radius),
		.out_valid(out_valid),
		.arc_u(arc_u),
		.axial_v(axial_v),
		.radial_w(radial_w),
		.in_material(in_material),
		.in_sensitive(in_sensitive)
	);

`ifndef SYNTHESIS
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("held result dropped");
	a_no_track_no_sens: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cfg_q.track |-> !in_sensitive)
		else $error("in_sensitive set on non tracking layer");
	a_zero_radius_arc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cfg_q.radius == '0 |-> arc_u == '0)
		else $error("arc length nonzero with zero radius");
	a_frozen_last_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_c[CORDIC_STAGES]))
		else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire
